@@ rtl/vap_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vap_pkg
// Shared constants, types and helpers of the 2-D vector / polar unit.
// ----------------------------------------------------------------------------
package vap_pkg;

  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned CORDIC_STAGES = 16;
  localparam int unsigned ATAN_LEN      = 24;
  localparam int unsigned GUARD         = 16;
  // CORDIC datapath widths: x/y with guard bits and growth, z as binary angle
  localparam int unsigned CW = 50;
  localparam int unsigned ZW = 34;

  localparam logic [29:0] K_Q30        = 30'd652032874;
  localparam logic [31:0] PI_Q30       = 32'd3373259426;
  localparam logic [63:0] TURN_PER_DEG = 64'd51240955760304310;
  localparam logic [63:0] TURN_PER_RAD = 64'h28BE60DB9391054A;

  // atan(2^-i) in binary angle units (2^32 per turn)
  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef enum logic [2:0] {
    FN_ADD, FN_SUB, FN_SCALE, FN_DOT, FN_POL_DEG, FN_POL_RAD, FN_MAG_RAD, FN_MAG_DEG
  } func_e;

  // results that are final before the CORDIC, carried alongside it
  typedef struct packed {
    func_e       func;
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rs;
    logic        ov;
  } side_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 rot;   // 1: rotation (z driven), 0: vectoring (y driven)
    logic                 flip;  // result negated after a half-turn fold
    logic                 zero;  // zero input vector
  } cord_t;

  // {overflow, saturated value}
  function automatic logic [32:0] sat32(input logic signed [71:0] v);
    logic [32:0] r;
    if (v > 72'sd2147483647) r = {1'b1, 32'h7FFF_FFFF};
    else if (v < -72'sd2147483648) r = {1'b1, 32'h8000_0000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

endpackage

@@ rtl/vap_prep.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vap_prep
// Two front stages: products and sums, then rounding, saturation of the
// linear operations and set-up of the CORDIC start vector.
// ----------------------------------------------------------------------------
module vap_prep import vap_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [2:0]         func_i,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic signed [31:0] scale_factor_i,
  input  logic signed [31:0] magnitude_i,
  input  logic signed [31:0] angle_i,
  output logic               valid_o,
  output side_t              side_o,
  output cord_t              cord_o
);

  localparam logic signed [66:0] HALF_F = 67'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] HALF_R = 64'sd1 <<< (30 - GUARD - 1);

  // ---------------- stage 1 ----------------
  func_e               func;
  logic                is_pol, is_dot;
  logic [31:0]         ang_abs;
  logic [63:0]         turn_k;
  logic signed [65:0]  op_a0, op_b0, op_a1, op_b1;
  logic signed [63:0]  mag_e, k_e;
  logic signed [CW-1:0] vx, vy;

  logic                 s1_valid_q;
  func_e                s1_func_q;
  logic                 s1_neg_q, s1_vzh_q, s1_zero_q;
  logic signed [32:0]   s1_sx_q, s1_sy_q;
  logic signed [65:0]   s1_m0_q, s1_m1_q;
  logic signed [63:0]   s1_m2_q;
  logic signed [CW-1:0] s1_vx_q, s1_vy_q;

  always_comb begin
    func    = func_e'(func_i);
    is_pol  = (func == FN_POL_DEG) || (func == FN_POL_RAD);
    is_dot  = (func == FN_DOT);
    ang_abs = angle_i[31] ? (~angle_i + 32'd1) : angle_i;
    turn_k  = (func == FN_POL_DEG) ? TURN_PER_DEG : TURN_PER_RAD;
    op_a0 = is_pol ? {34'd0, ang_abs} : {{34{a_x_i[31]}}, a_x_i};
    op_a1 = is_pol ? {34'd0, ang_abs} : {{34{a_y_i[31]}}, a_y_i};
    op_b0 = is_pol ? {34'd0, turn_k[31:0]} :
            is_dot ? {{34{b_x_i[31]}}, b_x_i} : {{34{scale_factor_i[31]}}, scale_factor_i};
    op_b1 = is_pol ? {34'd0, turn_k[63:32]} :
            is_dot ? {{34{b_y_i[31]}}, b_y_i} : {{34{scale_factor_i[31]}}, scale_factor_i};
    mag_e = {{32{magnitude_i[31]}}, magnitude_i};
    k_e   = {34'd0, K_Q30};
    vx = {{(CW-32-GUARD){a_x_i[31]}}, a_x_i, {GUARD{1'b0}}};
    vy = {{(CW-32-GUARD){a_y_i[31]}}, a_y_i, {GUARD{1'b0}}};
    // fold the left half-plane onto the right one
    if (a_x_i[31]) begin
      vx = -vx;
      vy = -vy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_func_q <= func;
      s1_neg_q  <= angle_i[31];
      s1_sx_q   <= (func == FN_SUB) ? ({a_x_i[31], a_x_i} - {b_x_i[31], b_x_i})
                                    : ({a_x_i[31], a_x_i} + {b_x_i[31], b_x_i});
      s1_sy_q   <= (func == FN_SUB) ? ({a_y_i[31], a_y_i} - {b_y_i[31], b_y_i})
                                    : ({a_y_i[31], a_y_i} + {b_y_i[31], b_y_i});
      s1_m0_q   <= op_a0 * op_b0;
      s1_m1_q   <= op_a1 * op_b1;
      s1_m2_q   <= mag_e * k_e;
      s1_vx_q   <= vx;
      s1_vy_q   <= vy;
      s1_vzh_q  <= a_x_i[31];
      s1_zero_q <= (a_x_i == '0) && (a_y_i == '0);
    end
  end

  // ---------------- stage 2 ----------------
  logic signed [66:0] sc_x, sc_y, dsum;
  logic [63:0]        mid, mid_r;
  logic [31:0]        t, th, th_p, th2;
  logic               flip;
  logic signed [63:0] rot_x;
  logic [32:0]        sat_a, sat_b;
  side_t              side_d;
  cord_t              cord_d;

  logic  valid_q;
  side_t side_q;
  cord_t cord_q;

  always_comb begin
    sc_x  = ($signed({s1_m0_q[65], s1_m0_q}) + HALF_F) >>> FRAC_BITS;
    sc_y  = ($signed({s1_m1_q[65], s1_m1_q}) + HALF_F) >>> FRAC_BITS;
    dsum  = ($signed({s1_m0_q[65], s1_m0_q}) + $signed({s1_m1_q[65], s1_m1_q}) + HALF_F)
            >>> FRAC_BITS;
    mid   = s1_m1_q[63:0] + {32'd0, s1_m0_q[63:32]};
    mid_r = (mid + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    t     = mid_r[31:0];
    th    = s1_neg_q ? (32'd0 - t) : t;
    th_p  = th + 32'h4000_0000;
    flip  = th_p[31];
    th2   = flip ? (th - 32'h8000_0000) : th;
    rot_x = (s1_m2_q + HALF_R) >>> (30 - GUARD);

    side_d      = '0;
    side_d.func = s1_func_q;
    cord_d      = '0;
    sat_a       = '0;
    sat_b       = '0;
    unique case (s1_func_q) inside
      FN_ADD, FN_SUB: begin
        sat_a = sat32(72'(s1_sx_q));
        sat_b = sat32(72'(s1_sy_q));
        side_d.rx = sat_a[31:0];
        side_d.ry = sat_b[31:0];
        side_d.ov = sat_a[32] | sat_b[32];
      end
      FN_SCALE: begin
        sat_a = sat32(72'(sc_x));
        sat_b = sat32(72'(sc_y));
        side_d.rx = sat_a[31:0];
        side_d.ry = sat_b[31:0];
        side_d.ov = sat_a[32] | sat_b[32];
      end
      FN_DOT: begin
        sat_a = sat32(72'(dsum));
        side_d.rs = sat_a[31:0];
        side_d.ov = sat_a[32];
      end
      FN_POL_DEG, FN_POL_RAD: begin
        cord_d.x    = rot_x[CW-1:0];
        cord_d.z    = {{(ZW-32){th2[31]}}, th2};
        cord_d.rot  = 1'b1;
        cord_d.flip = flip;
      end
      FN_MAG_RAD, FN_MAG_DEG: begin
        cord_d.x    = s1_vx_q;
        cord_d.y    = s1_vy_q;
        cord_d.z    = s1_vzh_q ? {{(ZW-32){1'b0}}, 32'h8000_0000} : '0;
        cord_d.zero = s1_zero_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
      cord_q <= cord_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign cord_o  = cord_q;

endmodule

@@ rtl/vap_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vap_cordic
// Unrolled CORDIC, one micro-rotation per register stage. Rotation mode
// steers by the sign of z, vectoring mode by the sign of y.
// ----------------------------------------------------------------------------
module vap_cordic import vap_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  side_t side_i,
  input  cord_t cord_i,
  output logic  valid_o,
  output side_t side_o,
  output cord_t cord_o
);

  localparam int unsigned N = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  logic [N:0] valid_w;
  side_t      side_w [N+1];
  cord_t      cord_w [N+1];

  assign valid_w[0] = valid_i;
  assign side_w[0]  = side_i;
  assign cord_w[0]  = cord_i;

  for (genvar i = 0; i < N; i++) begin : g_stage
    cord_t                c, n;
    logic signed [CW-1:0] xs, ys, dx, dy;
    logic signed [ZW-1:0] zs, da;
    logic                 d;
    logic                 valid_q;
    side_t                side_q;
    cord_t                cord_q;

    always_comb begin
      c  = cord_w[i];
      xs = c.x;
      ys = c.y;
      zs = c.z;
      dx = ys >>> i;
      dy = xs >>> i;
      da = ZW'(ATAN_TAB[i]);
      d  = c.rot ? ~zs[ZW-1] : ys[CW-1];
      n  = c;
      if (d) begin
        n.x = xs - dx;
        n.y = ys + dy;
        n.z = zs - da;
      end else begin
        n.x = xs + dx;
        n.y = ys - dy;
        n.z = zs + da;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else if (en_i) begin
        valid_q <= valid_w[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q <= side_w[i];
        cord_q <= n;
      end
    end

    assign valid_w[i+1] = valid_q;
    assign side_w[i+1]  = side_q;
    assign cord_w[i+1]  = cord_q;
  end

  assign valid_o = valid_w[N];
  assign side_o  = side_w[N];
  assign cord_o  = cord_w[N];

endmodule

@@ rtl/vap_post.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vap_post
// Back end: gain compensation and angle scaling products, then rounding,
// saturation and the output register.
// ----------------------------------------------------------------------------
module vap_post import vap_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  side_t              side_i,
  input  cord_t              cord_i,
  output logic               out_valid_o,
  output logic signed [31:0] res_x_o,
  output logic signed [31:0] res_y_o,
  output logic signed [31:0] res_scalar_o,
  output logic signed [31:0] res_angle_o,
  output logic               overflow_o
);

  localparam logic signed [CW:0]  HALF_G   = (CW+1)'(1) <<< (GUARD - 1);
  localparam logic signed [65:0]  HALF_RAD = 66'sd1 <<< (60 - FRAC_BITS);
  localparam logic signed [65:0]  HALF_DEG = 66'sd1 <<< (28 - FRAC_BITS);

  // ---------------- stage F1 ----------------
  logic signed [CW-1:0] xs, ys;
  logic signed [CW:0]   xr, yr;
  logic signed [35:0]   rx, ry;
  logic [CW-1:0]        xu;
  logic [31:0]          z32;
  logic signed [32:0]   zsv;
  logic signed [65:0]   zs_e, kc;

  logic                 f1_valid_q;
  side_t                f1_side_q;
  logic                 f1_zero_q;
  logic signed [35:0]   f1_rx_q, f1_ry_q;
  logic [53:0]          f1_pa_q;
  logic [56:0]          f1_pb_q;
  logic signed [65:0]   f1_pang_q;

  always_comb begin
    xs  = cord_i.x;
    ys  = cord_i.y;
    xr  = ($signed({xs[CW-1], xs}) + HALF_G) >>> GUARD;
    yr  = ($signed({ys[CW-1], ys}) + HALF_G) >>> GUARD;
    rx  = xr[35:0];
    ry  = yr[35:0];
    if (cord_i.flip) begin
      rx = -rx;
      ry = -ry;
    end
    xu   = cord_i.x;
    z32  = cord_i.z[31:0];
    // exactly half a turn stays positive
    zsv  = (z32 > 32'h8000_0000) ? {1'b1, z32} : {1'b0, z32};
    zs_e = {{33{zsv[32]}}, zsv};
    kc   = (side_i.func == FN_MAG_RAD) ? {34'd0, PI_Q30} : 66'sd45;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else if (en_i) begin
      f1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_side_q <= side_i;
      f1_zero_q <= cord_i.zero;
      f1_rx_q   <= rx;
      f1_ry_q   <= ry;
      f1_pa_q   <= 54'(xu[CW-1:26]) * 54'(K_Q30);
      f1_pb_q   <= 57'(xu[25:0]) * 57'(K_Q30) + (57'd1 << 45);
      f1_pang_q <= zs_e * kc;
    end
  end

  // ---------------- stage F2 ----------------
  logic               f1_mag;
  logic [54:0]        msum;
  logic [34:0]        mag;
  logic signed [65:0] ang;
  logic [32:0]        sat_a, sat_b;
  logic [31:0]        rx_d, ry_d, rs_d, ra_d;
  logic               ov_d;

  logic               out_valid_q, ov_q;
  logic [31:0]        rx_q, ry_q, rs_q, ra_q;

  assign f1_mag = (f1_side_q.func == FN_MAG_RAD) || (f1_side_q.func == FN_MAG_DEG);

  always_comb begin
    msum = {1'b0, f1_pa_q} + 55'(f1_pb_q >> 26);
    mag  = msum[54:20];
    ang  = (f1_side_q.func == FN_MAG_RAD) ? ((f1_pang_q + HALF_RAD) >>> (61 - FRAC_BITS))
                                          : ((f1_pang_q + HALF_DEG) >>> (29 - FRAC_BITS));
    rx_d  = f1_side_q.rx;
    ry_d  = f1_side_q.ry;
    rs_d  = f1_side_q.rs;
    ra_d  = '0;
    ov_d  = f1_side_q.ov;
    sat_a = '0;
    sat_b = '0;
    unique case (f1_side_q.func) inside
      FN_POL_DEG, FN_POL_RAD: begin
        sat_a = sat32(72'(f1_rx_q));
        sat_b = sat32(72'(f1_ry_q));
        rx_d  = sat_a[31:0];
        ry_d  = sat_b[31:0];
        ov_d  = sat_a[32] | sat_b[32];
      end
      FN_MAG_RAD, FN_MAG_DEG: begin
        sat_a = sat32(72'(mag));
        sat_b = sat32(72'(ang));
        if (f1_zero_q) begin
          rs_d = '0;
          ov_d = 1'b0;
        end else begin
          rs_d = sat_a[31:0];
          ra_d = sat_b[31:0];
          ov_d = sat_a[32] | sat_b[32];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q <= rx_d;
      ry_q <= ry_d;
      rs_q <= rs_d;
      ra_q <= ra_d;
      ov_q <= ov_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign res_x_o      = rx_q;
  assign res_y_o      = ry_q;
  assign res_scalar_o = rs_q;
  assign res_angle_o  = ra_q;
  assign overflow_o   = ov_q;

  // only the magnitude operations produce an angle
  a_angle_only_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && f1_valid_q && !f1_mag |=> res_angle_o == '0)
    else $error("angle output nonzero for a non-magnitude item");

  a_zero_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && f1_valid_q && f1_mag && f1_zero_q |=> res_scalar_o == '0 && res_angle_o == '0)
    else $error("zero vector did not give zero magnitude and angle");

  a_mag_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && f1_valid_q && f1_mag |=> !res_scalar_o[31])
    else $error("negative magnitude");

endmodule

@@ rtl/vector2d_arith_polar_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector2d_arith_polar_unit
// 2-D vector arithmetic and polar/cartesian conversion in signed Q16.16.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_stall_o is low and returns one result per
// item, in order. Every item runs the full pipeline whatever the operation: two
// front stages (products, rounding and CORDIC set-up), CORDIC_STAGES unrolled
// CORDIC stages, and two back stages (gain and angle scaling, saturation and
// the output register).
// A stall on the output freezes the whole pipeline, so in_stall_o follows
// out_stall_i only while a result is waiting at the output.
module vector2d_arith_polar_unit import vap_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         func_i,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic signed [31:0] scale_factor_i,
  input  logic signed [31:0] magnitude_i,
  input  logic signed [31:0] angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] res_x_o,
  output logic signed [31:0] res_y_o,
  output logic signed [31:0] res_scalar_o,
  output logic signed [31:0] res_angle_o,
  output logic               overflow_o
);

  logic  en;
  logic  pre_valid, cor_valid;
  side_t pre_side, cor_side;
  cord_t pre_cord, cor_cord;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  vap_prep u_prep (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (in_valid_i),
    .func_i         (func_i),
    .a_x_i          (a_x_i),
    .a_y_i          (a_y_i),
    .b_x_i          (b_x_i),
    .b_y_i          (b_y_i),
    .scale_factor_i (scale_factor_i),
    .magnitude_i    (magnitude_i),
    .angle_i        (angle_i),
    .valid_o        (pre_valid),
    .side_o         (pre_side),
    .cord_o         (pre_cord)
  );

  vap_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pre_valid),
    .side_i  (pre_side),
    .cord_i  (pre_cord),
    .valid_o (cor_valid),
    .side_o  (cor_side),
    .cord_o  (cor_cord)
  );

  vap_post u_post (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (cor_valid),
    .side_i       (cor_side),
    .cord_i       (cor_cord),
    .out_valid_o  (out_valid_o),
    .res_x_o      (res_x_o),
    .res_y_o      (res_y_o),
    .res_scalar_o (res_scalar_o),
    .res_angle_o  (res_angle_o),
    .overflow_o   (overflow_o)
  );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 2-D vector / polar unit. Items go in through a
// valid/stall handshake with random gaps, and results are checked in order
// against a bit-exact fixed-point CORDIC predictor, also under output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import vap_pkg::*;

  typedef struct {
    func_e              func;
    logic signed [31:0] ax, ay, bx, by, sf, mag, ang;
  } vec_item_t;

  typedef struct {
    logic signed [31:0] rx, ry, rs, ra;
    logic               ov;
  } vec_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         func_i = '0;
  logic signed [31:0] a_x_i = '0, a_y_i = '0, b_x_i = '0, b_y_i = '0;
  logic signed [31:0] scale_factor_i = '0, magnitude_i = '0, angle_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] res_x_o, res_y_o, res_scalar_o, res_angle_o;
  logic               overflow_o;

  vec_res_t expected_q[$];
  int  n_errors   = 0;
  int  n_sent     = 0;
  int  n_checked  = 0;
  int  n_ovf      = 0;
  bit  no_idle    = 1'b0;
  bit  hold_req   = 1'b0;
  int  hold_left  = 0;
  int  quiet_cyc  = 0;

  localparam int WATCHDOG_LIMIT = 5000;

  always #10 clk_i = ~clk_i;

  vector2d_arith_polar_unit dut (.*);

  // ---------------------------------------------------------------- predictor
  function automatic longint round_shift(longint v, int s);
    logic [63:0] mask, low;
    mask = (64'd1 << s) - 64'd1;
    low  = (v & mask) + (64'd1 << (s - 1));
    return (v >>> s) + longint'(low >> s);
  endfunction

  function automatic logic [31:0] clamp32(longint v, ref bit ov);
    if (v > 64'sd2147483647) begin
      ov = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      ov = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] angle_to_turns(longint v, logic [63:0] g);
    logic [63:0] u, lo, mid;
    logic [31:0] t;
    u   = (v < 0) ? -v : v;
    lo  = u * {32'd0, g[31:0]};
    mid = u * (g >> 32) + (lo >> 32);
    t   = 32'((mid + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
    return (v < 0) ? -t : t;
  endfunction

  function automatic void cordic_rotate(longint m, logic [31:0] th,
                                        output longint rx, output longint ry);
    logic [31:0] thq;
    bit          flip;
    longint      x, y, z, dx, dy;
    thq  = th + 32'h4000_0000;
    flip = thq[31];
    if (flip) th = th - 32'h8000_0000;
    z = longint'($signed(th));
    x = round_shift(m * longint'(K_Q30), 30 - GUARD);
    y = 0;
    for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
    x  = round_shift(x, GUARD);
    y  = round_shift(y, GUARD);
    rx = flip ? -x : x;
    ry = flip ? -y : y;
  endfunction

  function automatic void cordic_vector(longint ax, longint ay,
                                        output longint m, output longint zs);
    longint      x, y, dx, dy;
    logic [31:0] z;
    logic [63:0] xf, a, b;
    m  = 0;
    zs = 0;
    if (ax == 0 && ay == 0) return;
    x = ax * 65536;
    y = ay * 65536;
    z = '0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h8000_0000;
    end
    for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z = z + ATAN_TAB[i];
      end else begin
        x -= dx; y += dy; z = z - ATAN_TAB[i];
      end
    end
    xf = x;
    a  = (xf >> 26) * 64'(K_Q30);
    b  = (xf & 64'h3FF_FFFF) * 64'(K_Q30) + (64'd1 << 45);
    m  = longint'((a + (b >> 26)) >> 20);
    zs = (z > 32'h8000_0000) ? longint'(z) - 64'sh1_0000_0000 : longint'(z);
  endfunction

  function automatic vec_res_t predict_vector_op(vec_item_t it);
    longint   ax, ay, bx, by, rx, ry, rs, ra, p1, p2, zs;
    logic [63:0] mask, low;
    bit       ov;
    vec_res_t r;
    ax = it.ax; ay = it.ay; bx = it.bx; by = it.by;
    rx = 0; ry = 0; rs = 0; ra = 0; ov = 1'b0;
    case (it.func)
      FN_ADD: begin
        rx = ax + bx; ry = ay + by;
      end
      FN_SUB: begin
        rx = ax - bx; ry = ay - by;
      end
      FN_SCALE: begin
        rx = round_shift(ax * longint'(it.sf), FRAC_BITS);
        ry = round_shift(ay * longint'(it.sf), FRAC_BITS);
      end
      FN_DOT: begin
        // exact sum of both products, rounded once
        p1   = ax * bx;
        p2   = ay * by;
        mask = (64'd1 << FRAC_BITS) - 64'd1;
        low  = (p1 & mask) + (p2 & mask) + (64'd1 << (FRAC_BITS - 1));
        rs   = (p1 >>> FRAC_BITS) + (p2 >>> FRAC_BITS) + longint'(low >> FRAC_BITS);
      end
      FN_POL_DEG: cordic_rotate(it.mag, angle_to_turns(it.ang, TURN_PER_DEG), rx, ry);
      FN_POL_RAD: cordic_rotate(it.mag, angle_to_turns(it.ang, TURN_PER_RAD), rx, ry);
      default: begin
        cordic_vector(ax, ay, rs, zs);
        if (it.func == FN_MAG_RAD) ra = round_shift(zs * longint'(PI_Q30), 61 - FRAC_BITS);
        else                       ra = round_shift(zs * 45, 29 - FRAC_BITS);
      end
    endcase
    r.rx = clamp32(rx, ov);
    r.ry = clamp32(ry, ov);
    r.rs = clamp32(rs, ov);
    r.ra = clamp32(ra, ov);
    r.ov = ov;
    return r;
  endfunction

  // ---------------------------------------------------------------- sender
  task automatic send_item(vec_item_t it);
    while (!no_idle && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= it.func;
    a_x_i          <= it.ax;
    a_y_i          <= it.ay;
    b_x_i          <= it.bx;
    b_y_i          <= it.by;
    scale_factor_i <= it.sf;
    magnitude_i    <= it.mag;
    angle_i        <= it.ang;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(predict_vector_op(it));
    n_sent++;
    @(negedge clk_i);
  endtask

  function automatic vec_item_t mk(func_e f, logic [31:0] ax, logic [31:0] ay,
                                   logic [31:0] bx, logic [31:0] by, logic [31:0] sf,
                                   logic [31:0] mag, logic [31:0] ang);
    vec_item_t it;
    it.func = f; it.ax = ax; it.ay = ay; it.bx = bx; it.by = by;
    it.sf = sf; it.mag = mag; it.ang = ang;
    return it;
  endfunction

  // mostly moderate operands so results stay in range, some full-width
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
      2:       return $signed($urandom_range(32'h000F_FFFF)) - 32'sh0008_0000;
      default: return $signed($urandom_range(1023)) - 512;
    endcase
  endfunction

  function automatic vec_item_t rand_item();
    return mk(func_e'($urandom_range(7)), rand_operand(), rand_operand(),
              rand_operand(), rand_operand(), rand_operand(), rand_operand(),
              ($urandom_range(3) == 0) ? $urandom : rand_operand());
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------- receiver
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !no_idle && ($urandom_range(99) < 38);
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    vec_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h", $time, res_x_o, res_y_o);
        n_errors++;
      end else begin
        e = expected_q.pop_front();
        check_field("res_x", e.rx, res_x_o);
        check_field("res_y", e.ry, res_y_o);
        check_field("res_scalar", e.rs, res_scalar_o);
        check_field("res_angle", e.ra, res_angle_o);
        check_field("overflow", {31'd0, e.ov}, {31'd0, overflow_o});
        if (e.ov) n_ovf++;
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cyc = 0;
    else quiet_cyc++;
    if (quiet_cyc >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, expected_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_add_sub();
    send_item(mk(FN_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 0, 0, 0));
    send_item(mk(FN_ADD, 32'h0001_8000, 32'hFFFE_0000, 32'h0000_8000, 32'h0003_0000,
                 0, 0, 0));
    send_item(mk(FN_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF, 0, 0, 0));
    send_item(mk(FN_SUB, 32'h0005_0000, 32'h0, 32'h0002_0000, 32'h8000_0000, 0, 0, 0));
  endtask

  task automatic test_scale_dot();
    send_item(mk(FN_SCALE, 32'h0002_0000, 32'hFFFF_8000, 0, 0, 32'h0001_8000, 0, 0));
    send_item(mk(FN_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'h8000_0000, 0, 0));
    send_item(mk(FN_SCALE, 32'd1, 32'hFFFF_FFFF, 0, 0, 32'h0000_8000, 0, 0));
    send_item(mk(FN_DOT, 32'h0003_0000, 32'h0004_0000, 32'h0002_0000, 32'hFFFF_0000,
                 0, 0, 0));
    send_item(mk(FN_DOT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 0, 0, 0));
    send_item(mk(FN_DOT, 32'd1, 32'd1, 32'h0000_8000, 32'h0000_8000, 0, 0, 0));
  endtask

  task automatic test_polar();
    // quadrant edges, the fold region, huge angles and extreme magnitudes
    send_item(mk(FN_POL_DEG, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0000_0000));
    send_item(mk(FN_POL_DEG, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h005A_0000));
    send_item(mk(FN_POL_DEG, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h00B4_0000));
    send_item(mk(FN_POL_DEG, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h010E_0000));
    send_item(mk(FN_POL_DEG, 0, 0, 0, 0, 0, 32'h8000_0000, 32'hFF4C_0000));
    send_item(mk(FN_POL_DEG, 0, 0, 0, 0, 0, 32'h0010_0000, 32'h7FFF_FFFF));
    send_item(mk(FN_POL_RAD, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0003_243F));
    send_item(mk(FN_POL_RAD, 0, 0, 0, 0, 0, 32'h0100_0000, 32'h8000_0000));
  endtask

  task automatic test_to_polar();
    send_item(mk(FN_MAG_RAD, 0, 0, 0, 0, 0, 0, 0));                       // zero vector
    send_item(mk(FN_MAG_DEG, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(FN_MAG_DEG, 32'hFFFF_0000, 0, 0, 0, 0, 0, 0));           // negative x axis
    send_item(mk(FN_MAG_RAD, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
    send_item(mk(FN_MAG_RAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0)); // big magnitude
    send_item(mk(FN_MAG_DEG, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0));
    send_item(mk(FN_MAG_DEG, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random(int n);
    repeat (n) send_item(rand_item());
  endtask

  task automatic test_back_to_back(int n);
    no_idle = 1'b1;
    test_random(n);
    no_idle = 1'b0;
  endtask

  task automatic test_output_hold();
    // long receiver hold while items keep coming, so the pipe fills and stalls
    hold_req = 1'b1;
    test_random(100);
  endtask

  task automatic test_drain_pause();
    test_random(40);
    wait_drained();
    test_random(40);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_add_sub();
    test_scale_dot();
    test_polar();
    test_to_polar();
    test_back_to_back(300);
    test_output_hold();
    test_drain_pause();
    test_random(950);
    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("Sent %0d items over all eight operations, %0d results checked (%0d saturated),",
             n_sent, n_checked, n_ovf);
    $display("with random gaps, back-to-back bursts, a long output hold and a full drain.");
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
